// ===== rtl/uctp_pkg.sv =====
// Shared types for the UTF-8 color tag parser: front/back operation items
// and the front sequencer states. No dependencies.

package uctp_pkg;

    // Operations the front hands to the back through the queue.
    typedef enum logic [2:0] {
        OP_DECODE = 3'd0,   // run one byte through the UTF-8 decoder
        OP_EMIT   = 3'd1,   // send one code point out as is
        OP_FLUSH  = 3'd2,   // send out a truncated sequence, if any
        OP_END    = 3'd3,   // end of text: flush, go back to default color
        OP_SETCOL = 3'd4,   // color tag: use the carried RGB value
        OP_SETDEF = 3'd5    // closing tag: follow the default color
    } t_op_kind;

    typedef struct packed {
        t_op_kind    kind;
        logic [23:0] data;  // byte in [7:0] or RGB in [23:0]
        logic        last;  // last operation caused by its input item
    } t_op;

    typedef enum logic {
        FS_ACCEPT = 1'b0,
        FS_REPLAY = 1'b1
    } t_front_state;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BLUE  = 2'd2;

endpackage

// ===== rtl/uctp_queue.sv =====
// Small FIFO of operation items between front and back.
// Depends on uctp_pkg (t_op).

module uctp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uctp_pkg::t_op i_op,
    output logic          o_full,
    output logic          o_valid,
    output uctp_pkg::t_op o_op,
    input  logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    uctp_pkg::t_op    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)))
        else $error("queue written while full");
`endif

endmodule

// ===== rtl/uctp_front.sv =====
// Front end: accepts text bytes, tracks tags, and turns each byte into
// queue operations, replaying a failed tag body. Depends on uctp_pkg.

module uctp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [7:0]    i_text_byte,
    output logic          o_in_stall,
    input  logic          i_q_full,
    output logic          o_push,
    output uctp_pkg::t_op o_op
);

    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_NUL   = 8'h00;

    // {valid, nibble}
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    uctp_pkg::t_front_state r_state, n_state;
    logic                   r_in_tag, n_in_tag;
    logic [2:0]             r_len, n_len;
    logic [7:0]             r_body [7];
    logic [2:0]             r_rep_len, n_rep_len;
    logic [2:0]             r_rep_idx, n_rep_idx;
    logic                   r_trail_valid, n_trail_valid;
    uctp_pkg::t_op_kind     r_trail_kind, n_trail_kind;
    logic [7:0]             r_trail_data, n_trail_data;

    logic        accept;
    logic        body_we;
    logic [2:0]  body_idx;
    logic [4:0]  hd [6];
    logic        all_hex;
    logic        tag_def;
    logic        tag_col;
    logic [23:0] tag_rgb;
    logic        rep_last;

    always_comb begin
        all_hex = 1'b1;
        for (int i = 0; i < 6; i++) begin
            hd[i]   = decode_hex(r_body[i]);
            all_hex = all_hex && hd[i][4];
        end
        tag_rgb = {hd[0][3:0], hd[1][3:0], hd[2][3:0], hd[3][3:0], hd[4][3:0], hd[5][3:0]};
        tag_def = (r_len == 3'd1) && (r_body[0] == CH_SLASH);
        tag_col = (r_len == 3'd6) && all_hex;
    end

    assign o_in_stall = (r_state != uctp_pkg::FS_ACCEPT) || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign rep_last   = (3'(r_rep_idx + 3'd1) == r_rep_len);

    always_comb begin
        n_state       = r_state;
        n_in_tag      = r_in_tag;
        n_len         = r_len;
        n_rep_len     = r_rep_len;
        n_rep_idx     = r_rep_idx;
        n_trail_valid = r_trail_valid;
        n_trail_kind  = r_trail_kind;
        n_trail_data  = r_trail_data;
        body_we       = 1'b0;
        body_idx      = r_len;
        o_push        = 1'b0;
        o_op          = '0;

        unique case (r_state)
            uctp_pkg::FS_ACCEPT: begin
                if (accept) begin
                    if (!r_in_tag) begin
                        o_push      = 1'b1;
                        o_op.last   = 1'b1;
                        o_op.data   = {16'd0, i_text_byte};
                        if (i_text_byte == CH_NUL) begin
                            o_op.kind = uctp_pkg::OP_END;
                        end else if (i_text_byte == CH_OPEN) begin
                            o_op.kind = uctp_pkg::OP_FLUSH;
                            n_in_tag  = 1'b1;
                            n_len     = '0;
                        end else begin
                            o_op.kind = uctp_pkg::OP_DECODE;
                        end
                    end else if (i_text_byte == CH_CLOSE && (tag_def || tag_col)) begin
                        o_push    = 1'b1;
                        o_op.last = 1'b1;
                        o_op.kind = tag_def ? uctp_pkg::OP_SETDEF : uctp_pkg::OP_SETCOL;
                        o_op.data = tag_rgb;
                        n_in_tag  = 1'b0;
                        n_len     = '0;
                    end else if (i_text_byte != CH_CLOSE && i_text_byte != CH_OPEN
                                 && i_text_byte != CH_NUL && r_len < 3'd6) begin
                        // ordinary tag body byte
                        body_we = 1'b1;
                        n_len   = 3'(r_len + 3'd1);
                    end else begin
                        // failed tag: '[' now, then the body, then the trailing byte
                        o_push        = 1'b1;
                        o_op.kind     = uctp_pkg::OP_EMIT;
                        o_op.data     = {16'd0, CH_OPEN};
                        o_op.last     = 1'b0;
                        n_state       = uctp_pkg::FS_REPLAY;
                        n_rep_idx     = '0;
                        n_rep_len     = r_len;
                        n_in_tag      = 1'b0;
                        n_len         = '0;
                        n_trail_valid = 1'b1;
                        n_trail_data  = i_text_byte;
                        n_trail_kind  = uctp_pkg::OP_DECODE;
                        if (i_text_byte == CH_OPEN) begin
                            n_trail_kind = uctp_pkg::OP_FLUSH;
                            n_in_tag     = 1'b1;
                        end else if (i_text_byte == CH_NUL) begin
                            n_trail_kind = uctp_pkg::OP_END;
                        end else if (i_text_byte != CH_CLOSE) begin
                            // seventh body byte: kept and replayed, nothing trails
                            body_we       = 1'b1;
                            body_idx      = 3'd6;
                            n_rep_len     = 3'd7;
                            n_trail_valid = 1'b0;
                        end
                    end
                end
            end
            uctp_pkg::FS_REPLAY: begin
                if (!i_q_full) begin
                    o_push = 1'b1;
                    if (r_rep_idx != r_rep_len) begin
                        o_op.kind = uctp_pkg::OP_DECODE;
                        o_op.data = {16'd0, r_body[r_rep_idx]};
                        o_op.last = rep_last && !r_trail_valid;
                        n_rep_idx = 3'(r_rep_idx + 3'd1);
                        if (rep_last && !r_trail_valid) begin
                            n_state = uctp_pkg::FS_ACCEPT;
                        end
                    end else begin
                        o_op.kind = r_trail_kind;
                        o_op.data = {16'd0, r_trail_data};
                        o_op.last = 1'b1;
                        n_state   = uctp_pkg::FS_ACCEPT;
                    end
                end
            end
            default: begin
                n_state = uctp_pkg::FS_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= uctp_pkg::FS_ACCEPT;
            r_in_tag      <= 1'b0;
            r_len         <= '0;
            r_rep_len     <= '0;
            r_rep_idx     <= '0;
            r_trail_valid <= 1'b0;
            r_trail_kind  <= uctp_pkg::OP_DECODE;
            r_trail_data  <= '0;
        end else begin
            r_state       <= n_state;
            r_in_tag      <= n_in_tag;
            r_len         <= n_len;
            r_rep_len     <= n_rep_len;
            r_rep_idx     <= n_rep_idx;
            r_trail_valid <= n_trail_valid;
            r_trail_kind  <= n_trail_kind;
            r_trail_data  <= n_trail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (body_we) begin
            r_body[body_idx] <= i_text_byte;
        end
    end

`ifndef ASSERT_OFF
    a_replay_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == uctp_pkg::FS_REPLAY) |-> (r_rep_idx <= r_rep_len))
        else $error("replay index ran past the held body");
`endif

endmodule

// ===== rtl/uctp_back.sv =====
// Back end: UTF-8 decoder, control-code filter, color state and the
// output stage that marks the last result of each item. Depends on uctp_pkg.

module uctp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_def_red,
    input  logic [7:0]    i_def_green,
    input  logic [7:0]    i_def_blue,
    input  logic          i_q_valid,
    input  uctp_pkg::t_op i_q_op,
    output logic          o_q_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [20:0]   o_code_point,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue,
    output logic          o_last_of_run
);

    typedef struct packed {
        logic [20:0] code_point;
        logic [23:0] rgb;
    } t_result;

    // decoder and color state
    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_owed, n_owed;
    logic        r_follow, n_follow;
    logic [23:0] r_colour, n_colour;
    // hold slot: newest result, kept until we know whether it ends its item
    logic        r_hold_valid, n_hold_valid;
    logic        r_hold_final, n_hold_final;
    t_result     r_hold, n_hold;
    // output register
    logic        r_out_valid, n_out_valid;
    logic        r_out_last, n_out_last;
    t_result     r_out, n_out;

    logic [7:0]  b;
    logic        raw_v;
    logic [20:0] raw_cp;
    logic        done;
    logic        c_v;
    t_result     c_res;
    logic [20:0] s_partial;
    logic [1:0]  s_owed;
    logic        s_follow;
    logic [23:0] s_colour;
    logic [20:0] cat;

    // one operation step
    always_comb begin
        b         = i_q_op.data[7:0];
        cat       = {r_partial[14:0], b[5:0]};
        raw_v     = 1'b0;
        raw_cp    = '0;
        done      = 1'b1;
        s_partial = r_partial;
        s_owed    = r_owed;
        s_follow  = r_follow;
        s_colour  = r_colour;

        unique case (i_q_op.kind)
            uctp_pkg::OP_DECODE: begin
                if (r_owed != 2'd0) begin
                    if (b[7:6] == 2'b10) begin
                        s_owed = 2'(r_owed - 2'd1);
                        if (r_owed == 2'd1) begin
                            raw_v     = 1'b1;
                            raw_cp    = cat;
                            s_partial = '0;
                        end else begin
                            s_partial = cat;
                        end
                    end else begin
                        // truncated sequence: send it, keep this byte in the queue and handle it again
                        raw_v     = 1'b1;
                        raw_cp    = r_partial;
                        s_owed    = '0;
                        s_partial = '0;
                        done      = 1'b0;
                    end
                end else if (b >= 8'hF0) begin
                    s_partial = {18'd0, b[2:0]};
                    s_owed    = 2'd3;
                end else if (b >= 8'hE0) begin
                    s_partial = {17'd0, b[3:0]};
                    s_owed    = 2'd2;
                end else if (b >= 8'hC0) begin
                    s_partial = {16'd0, b[4:0]};
                    s_owed    = 2'd1;
                end else begin
                    raw_v  = 1'b1;
                    raw_cp = {13'd0, b};
                end
            end
            uctp_pkg::OP_EMIT: begin
                raw_v  = 1'b1;
                raw_cp = {13'd0, b};
            end
            uctp_pkg::OP_FLUSH, uctp_pkg::OP_END: begin
                raw_v     = (r_owed != 2'd0);
                raw_cp    = r_partial;
                s_owed    = '0;
                s_partial = '0;
                if (i_q_op.kind == uctp_pkg::OP_END) begin
                    s_follow = 1'b1;
                end
            end
            uctp_pkg::OP_SETCOL: begin
                s_colour = i_q_op.data;
                s_follow = 1'b0;
            end
            uctp_pkg::OP_SETDEF: begin
                s_follow = 1'b1;
            end
            default: begin
            end
        endcase

        // newline survives, every other code below 0x20 (CR too) is dropped
        c_v              = raw_v && ((raw_cp >= 21'h20) || (raw_cp == 21'h0A));
        c_res.code_point = raw_cp;
        c_res.rgb        = r_follow ? {i_def_red, i_def_green, i_def_blue} : r_colour;
    end

    logic load_ok;
    logic drain;
    logic blocked;
    logic hold_live;
    logic load_left;
    logic item_end;
    logic go;

    always_comb begin
        load_ok   = !r_out_valid || !i_out_stall;
        drain     = r_hold_valid && r_hold_final && load_ok;
        blocked   = r_hold_valid && r_hold_final && !load_ok;
        hold_live = r_hold_valid && !r_hold_final;
        load_left = load_ok && !drain;
        item_end  = done && i_q_op.last;
        go        = 1'b0;

        n_out_valid  = r_out_valid && !load_ok;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_hold_valid = r_hold_valid;
        n_hold_final = r_hold_final;
        n_hold       = r_hold;

        if (drain) begin
            n_out_valid  = 1'b1;
            n_out        = r_hold;
            n_out_last   = 1'b1;
            n_hold_valid = 1'b0;
            n_hold_final = 1'b0;
        end

        if (i_q_valid && !blocked) begin
            if (!c_v) begin
                go = 1'b1;
                if (item_end && hold_live) begin
                    n_hold_final = 1'b1;
                end
            end else if (!hold_live) begin
                go = 1'b1;
                if (item_end && load_left) begin
                    n_out_valid = 1'b1;
                    n_out       = c_res;
                    n_out_last  = 1'b1;
                end else begin
                    n_hold_valid = 1'b1;
                    n_hold_final = item_end;
                    n_hold       = c_res;
                end
            end else if (load_left) begin
                go           = 1'b1;
                n_out_valid  = 1'b1;
                n_out        = r_hold;
                n_out_last   = 1'b0;
                n_hold_valid = 1'b1;
                n_hold_final = item_end;
                n_hold       = c_res;
            end
        end

        n_partial = go ? s_partial : r_partial;
        n_owed    = go ? s_owed    : r_owed;
        n_follow  = go ? s_follow  : r_follow;
        n_colour  = go ? s_colour  : r_colour;
    end

    assign o_q_pop       = go && done;
    assign o_out_valid   = r_out_valid;
    assign o_code_point  = r_out.code_point;
    assign o_red         = r_out.rgb[23:16];
    assign o_green       = r_out.rgb[15:8];
    assign o_blue        = r_out.rgb[7:0];
    assign o_last_of_run = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial    <= '0;
            r_owed       <= '0;
            r_follow     <= 1'b1;
            r_colour     <= 24'hFFFFFF;
            r_hold_valid <= 1'b0;
            r_hold_final <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_partial    <= n_partial;
            r_owed       <= n_owed;
            r_follow     <= n_follow;
            r_colour     <= n_colour;
            r_hold_valid <= n_hold_valid;
            r_hold_final <= n_hold_final;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

`ifndef ASSERT_OFF
    a_partial_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_owed == 2'd0) |-> (r_partial == 21'd0))
        else $error("partial code left over with no bytes owed");

    a_final_needs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_final |-> r_hold_valid)
        else $error("final mark on an empty hold slot");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/utf8_color_tag_parser.sv =====
// Top level of the UTF-8 color tag parser: config registers, front end,
// operation queue and back end. Depends on uctp_pkg, uctp_front, uctp_queue, uctp_back.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  in       | to block  | i_in_valid / o_in_stall    | i_text_byte
//  out      | from block| o_out_valid / i_out_stall  | o_code_point, o_red, o_green,
//           |           |                            | o_blue, o_last_of_run
//  cfg      | to block  | i_cfg_wr_en                | i_cfg_index, i_cfg_data
//
// Plain text runs at one byte per cycle while the queue is not full; each result is registered
// in the output register, or first in the hold slot. A failed tag stalls the input while the
// front sequencer replays the held body bytes and any trailing byte, pushing one operation per
// cycle into the queue while it is not full; the cycle taking the failing byte pushes the '['.
// A truncated UTF-8 sequence cut off by another byte is sent first; that byte is handled again.
// Reset is synchronous, active low; no clearing pass, tag body storage is not reset.
// Output stall fills the QUEUE_DEPTH-entry queue, which then stalls the input.

module utf8_color_tag_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // text in
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_text_byte,
    // code points out
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [20:0]                    o_code_point,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    output logic                           o_last_of_run,
    // config writes
    input  logic                           i_cfg_wr_en,
    input  logic [uctp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    // Default text color. Read live by the back end, so a write shows up
    // on the next item that runs in default color.
    logic [7:0] r_def_red;
    logic [7:0] r_def_green;
    logic [7:0] r_def_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_red   <= 8'hFF;
            r_def_green <= 8'hFF;
            r_def_blue  <= 8'hFF;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                uctp_pkg::CFG_DEFAULT_RED:   r_def_red   <= i_cfg_data;
                uctp_pkg::CFG_DEFAULT_GREEN: r_def_green <= i_cfg_data;
                uctp_pkg::CFG_DEFAULT_BLUE:  r_def_blue  <= i_cfg_data;
                default: begin
                    // unused index: write dropped
                end
            endcase
        end
    end

    // front -> queue -> back
    logic          push;
    uctp_pkg::t_op push_op;
    logic          q_full;
    logic          q_valid;
    uctp_pkg::t_op q_op;
    logic          q_pop;

    // Front: tag tracking and failed-tag replay; emits decode, emit, flush, end and color operations.
    uctp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_text_byte (i_text_byte),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_op        (push_op)
    );

    // Queue decouples the two sides so output stall does not stop the front at once.
    uctp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    // Back: UTF-8 decode, filtering, color, and last-of-run marking.
    uctp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_def_red     (r_def_red),
        .i_def_green   (r_def_green),
        .i_def_blue    (r_def_blue),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_code_point  (o_code_point),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_last_of_run (o_last_of_run)
    );

endmodule
